>>> sv/bar_range_volume_window_top_assert.svh
// Assertion macros shared by the bar range and volume window RTL.
`ifndef BAR_RANGE_VOLUME_WINDOW_TOP_ASSERT_SVH
`define BAR_RANGE_VOLUME_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define BRVW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brvw assertion failed");

// Next-cycle implication, checked only out of reset.
`define BRVW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brvw assertion failed");

`endif

>>> sv/brvw_pkg.sv
// Types and constants of the bar range and volume window block.
`default_nettype none

package brvw_pkg;

    localparam int PRICE_W   = 32;
    localparam int VOLUME_W  = 32;
    localparam int WINDOW_W  = 7;
    localparam int MINVOL_W  = 40;
    localparam int MEAN_W    = 40;
    localparam int Q_SHIFT   = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;

    // Register indexes, taken from paddr bit 3 (registers sit at 8-byte steps).
    localparam logic REG_WINDOW     = 1'b0;
    localparam logic REG_MIN_VOLUME = 1'b1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd14;
    localparam logic [MINVOL_W-1:0] MINVOL_RESET = 40'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRUE_RANGE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } brvw_state_t;

endpackage

`default_nettype wire

>>> sv/brvw_bar_if.sv
// Request channel carrying one price bar.
`default_nettype none

interface brvw_bar_if;
    import brvw_pkg::*;

    logic                valid;
    logic                ready;
    logic [PRICE_W-1:0]  bar_high;
    logic [PRICE_W-1:0]  bar_low;
    logic [PRICE_W-1:0]  bar_close;
    logic [VOLUME_W-1:0] bar_volume;

    modport source (output valid, output bar_high, output bar_low, output bar_close,
                    output bar_volume, input ready);
    modport sink   (input valid, input bar_high, input bar_low, input bar_close,
                    input bar_volume, output ready);
endinterface

`default_nettype wire

>>> sv/brvw_result_if.sv
// Request channel carrying the range and volume means of one bar.
`default_nettype none

interface brvw_result_if;
    import brvw_pkg::*;

    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] range_mean_q8;
    logic [MEAN_W-1:0] volume_mean_q8;
    logic              indicators_valid;

    modport source (output valid, output range_mean_q8, output volume_mean_q8,
                    output indicators_valid, input ready);
    modport sink   (input valid, input range_mean_q8, input volume_mean_q8,
                    input indicators_valid, output ready);
endinterface

`default_nettype wire

>>> sv/brvw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module brvw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/bar_range_volume_window_top.sv
// Bar range and volume window: moving means of true range and volume over price bars.
// A result is presented after its bar passes the true-range, update, divide and finish
// states; the bit-serial divider runs DIV_W = 46 steps for a 64-deep window.
// A bar is taken only once the last one is done; the next may enter while a result waits.
// Reset clears window length to 14, minimum volume to 256 and all history; ring
// contents are not cleared, since an entry is never used before it is written.
`default_nettype none

module bar_range_volume_window_top #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [brvw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [brvw_pkg::PDATA_W-1:0]  pwdata,
    output logic      [brvw_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    brvw_bar_if.sink                           bar,
    brvw_result_if.source                      result
);

    import brvw_pkg::*;

`include "bar_range_volume_window_top_assert.svh"

    // Widths that follow from the ring depth.
    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int BS_W     = $clog2(MAX_WINDOW + 2);
    localparam int EXT_W    = ((BS_W > WINDOW_W) ? BS_W : WINDOW_W) + 2;
    localparam int SUM_W    = PRICE_W + AW;
    localparam int DIV_W    = SUM_W + Q_SHIFT;
    localparam int CNT_W    = $clog2(DIV_W);
    localparam int RAM_W    = PRICE_W + VOLUME_W;

    localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_WINDOW);
    localparam logic [BS_W-1:0]  BS_MAX   = BS_W'(MAX_WINDOW + 1);
    localparam logic [AW-1:0]    POS_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The window length is clamped into
    // 1..MAX_WINDOW on write, and a window write clears the bar history.
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0] n_reg;
    logic [MINVOL_W-1:0] minvol_reg;
    logic                cfg_write;
    logic                cfg_window;
    logic [EXT_W-1:0]    win_raw;
    logic [WINDOW_W-1:0] win_clamped;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign cfg_window = cfg_write && (paddr[3] == REG_WINDOW);
    assign win_raw    = EXT_W'(pwdata[WINDOW_W-1:0]);

    always_comb
    begin
        if (win_raw == '0)
        begin
            win_clamped = WINDOW_W'(1);
        end
        else if (win_raw > MAX_EXT)
        begin
            win_clamped = MAX_EXT[WINDOW_W-1:0];
        end
        else
        begin
            win_clamped = pwdata[WINDOW_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_MIN_VOLUME)
        begin
            prdata = {{(PDATA_W - MINVOL_W){1'b0}}, minvol_reg};
        end
        else
        begin
            prdata = {{(PDATA_W - WINDOW_W){1'b0}}, n_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= WINDOW_RESET;
            minvol_reg <= MINVOL_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_WINDOW)
            begin
                n_reg <= win_clamped;
            end
            else
            begin
                minvol_reg <= pwdata[MINVOL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: each entry holds {true range, volume} of one bar.
    // The entry that leaves the window is read when the bar is accepted,
    // so the later write to the same entry (window equal to the depth)
    // cannot disturb it.
    // ------------------------------------------------------------------
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [RAM_W-1:0] ram_rd_data;
    logic [AW-1:0]    pos_reg;
    logic [PRICE_W-1:0]  tr_reg;
    logic [VOLUME_W-1:0] vol_reg;

    brvw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data ({tr_reg, vol_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    brvw_state_t state_reg;
    brvw_state_t state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic             out_valid_reg;
    logic             bar_accept;
    logic             out_free;

    assign bar.ready  = (state_reg == ST_IDLE);
    assign bar_accept = bar.valid && bar.ready;
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (bar_accept)
                begin
                    state_next = ST_TRUE_RANGE;
                end
            end
            ST_TRUE_RANGE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ram_rd_en = bar_accept;
            end
            ST_UPDATE:
            begin
                ram_wr_en = 1'b1;
            end
            default:
            begin
                ram_rd_en = 1'b0;
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // History and address arithmetic, done in a common wider width.
    // ------------------------------------------------------------------
    logic [BS_W-1:0]     bars_seen_reg;
    logic [BS_W-1:0]     bars_seen_next;
    logic [EXT_W-1:0]    n_ext;
    logic [EXT_W-1:0]    bs_ext;
    logic [EXT_W-1:0]    bs_next_ext;
    logic [EXT_W-1:0]    old_sum;
    logic [EXT_W-1:0]    old_wrap;
    logic [PRICE_W-1:0]  prev_close_reg;
    logic [SUM_W-1:0]    sum_r_reg;
    logic [SUM_W-1:0]    sum_v_reg;
    logic [SUM_W-1:0]    sum_r_next;
    logic [SUM_W-1:0]    sum_v_next;
    logic                drop_reg;
    logic                range_ok_reg;
    logic                vol_ok_reg;

    assign n_ext       = EXT_W'(n_reg);
    assign bs_ext      = EXT_W'(bars_seen_reg);
    assign bars_seen_next = (bars_seen_reg == BS_MAX) ? bars_seen_reg
                                                      : bars_seen_reg + BS_W'(1);
    assign bs_next_ext = EXT_W'(bars_seen_next);

    // Entry leaving the window: (pos - n) modulo the ring depth.
    assign old_sum     = EXT_W'(pos_reg) + MAX_EXT - n_ext;
    assign old_wrap    = (old_sum >= MAX_EXT) ? (old_sum - MAX_EXT) : old_sum;
    assign ram_rd_addr = old_wrap[AW-1:0];

    assign sum_r_next  = sum_r_reg + SUM_W'(tr_reg);
    assign sum_v_next  = sum_v_reg + SUM_W'(vol_reg);

    // True range of the held bar against the previous close. Low above
    // high makes the high-low span count as zero.
    logic [PRICE_W-1:0] high_reg;
    logic [PRICE_W-1:0] low_reg;
    logic [PRICE_W-1:0] close_reg;
    logic [PRICE_W-1:0] span_hl;
    logic [PRICE_W-1:0] dist_h;
    logic [PRICE_W-1:0] dist_l;
    logic [PRICE_W-1:0] tr_hl_h;
    logic [PRICE_W-1:0] tr_calc;

    assign span_hl = (high_reg >= low_reg) ? (high_reg - low_reg) : '0;
    assign dist_h  = (high_reg >= prev_close_reg) ? (high_reg - prev_close_reg)
                                                  : (prev_close_reg - high_reg);
    assign dist_l  = (low_reg >= prev_close_reg) ? (low_reg - prev_close_reg)
                                                 : (prev_close_reg - low_reg);
    assign tr_hl_h = (dist_h > span_hl) ? dist_h : span_hl;
    assign tr_calc = (bars_seen_reg == '0) ? '0
                   : ((dist_l > tr_hl_h) ? dist_l : tr_hl_h);

    always_ff @(posedge clk)
    begin
        if (bar_accept)
        begin
            high_reg  <= bar.bar_high;
            low_reg   <= bar.bar_low;
            close_reg <= bar.bar_close;
            vol_reg   <= bar.bar_volume;
        end
        if (state_reg == ST_TRUE_RANGE)
        begin
            tr_reg <= tr_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bars_seen_reg  <= '0;
            pos_reg        <= '0;
            prev_close_reg <= '0;
            sum_r_reg      <= '0;
            sum_v_reg      <= '0;
            drop_reg       <= 1'b0;
            range_ok_reg   <= 1'b0;
            vol_ok_reg     <= 1'b0;
        end
        else if (cfg_window)
        begin
            bars_seen_reg  <= '0;
            pos_reg        <= '0;
            prev_close_reg <= '0;
            sum_r_reg      <= '0;
            sum_v_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (bar_accept)
                    begin
                        drop_reg <= (bs_ext >= n_ext);
                    end
                end
                ST_TRUE_RANGE:
                begin
                    // The read data is the entry leaving the window.
                    if (drop_reg)
                    begin
                        sum_r_reg <= sum_r_reg - SUM_W'(ram_rd_data[RAM_W-1:VOLUME_W]);
                        sum_v_reg <= sum_v_reg - SUM_W'(ram_rd_data[VOLUME_W-1:0]);
                    end
                end
                ST_UPDATE:
                begin
                    sum_r_reg      <= sum_r_next;
                    sum_v_reg      <= sum_v_next;
                    pos_reg        <= (pos_reg == POS_LAST) ? '0 : pos_reg + AW'(1);
                    bars_seen_reg  <= bars_seen_next;
                    prev_close_reg <= close_reg;
                    range_ok_reg   <= (bs_next_ext >= n_ext + EXT_W'(1));
                    vol_ok_reg     <= (bs_next_ext >= n_ext);
                end
                default:
                begin
                    drop_reg <= drop_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Two restoring dividers run side by side, one quotient bit a cycle.
    // The dividend register shifts out its top bit and takes in the
    // quotient bit, so it holds the quotient once all bits are through.
    // The remainder stays below n, so it fits the window width.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]    quo_r_reg;
    logic [DIV_W-1:0]    quo_v_reg;
    logic [WINDOW_W-1:0] rem_r_reg;
    logic [WINDOW_W-1:0] rem_v_reg;
    logic [WINDOW_W:0]   trial_r;
    logic [WINDOW_W:0]   trial_v;
    logic                take_r;
    logic                take_v;

    assign trial_r = {rem_r_reg, quo_r_reg[DIV_W-1]};
    assign trial_v = {rem_v_reg, quo_v_reg[DIV_W-1]};
    assign take_r  = (trial_r >= {1'b0, n_reg});
    assign take_v  = (trial_v >= {1'b0, n_reg});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            quo_r_reg <= {sum_r_next, {Q_SHIFT{1'b0}}};
            quo_v_reg <= {sum_v_next, {Q_SHIFT{1'b0}}};
            rem_r_reg <= '0;
            rem_v_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            quo_r_reg <= {quo_r_reg[DIV_W-2:0], take_r};
            quo_v_reg <= {quo_v_reg[DIV_W-2:0], take_v};
            rem_r_reg <= take_r ? WINDOW_W'(trial_r - {1'b0, n_reg}) : trial_r[WINDOW_W-1:0];
            rem_v_reg <= take_v ? WINDOW_W'(trial_v - {1'b0, n_reg}) : trial_v[WINDOW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a result until taken while the next bar
    // is already being worked on; the finish step waits for it to free.
    // The range mean counts only after N+1 bars, the volume mean after N,
    // and a zero volume mean is replaced by the configured minimum.
    // ------------------------------------------------------------------
    logic [MEAN_W-1:0] range_out_reg;
    logic [MEAN_W-1:0] vol_out_reg;
    logic              ind_out_reg;
    logic              range_nz;
    logic              out_load;
    logic [MEAN_W-1:0] vol_mean;

    assign range_nz = range_ok_reg && (quo_r_reg != '0);
    assign out_load = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        if (!vol_ok_reg)
        begin
            vol_mean = '0;
        end
        else if (quo_v_reg == '0)
        begin
            vol_mean = minvol_reg;
        end
        else
        begin
            vol_mean = quo_v_reg[MEAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            range_out_reg <= range_ok_reg ? quo_r_reg[MEAN_W-1:0] : '0;
            vol_out_reg   <= vol_mean;
            ind_out_reg   <= range_nz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.range_mean_q8    = range_out_reg;
    assign result.volume_mean_q8   = vol_out_reg;
    assign result.indicators_valid = ind_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `BRVW_ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(out_valid_reg),
                       $past(state_reg) == ST_FINISH)
    `BRVW_ASSERT_IMPLY(a_window_legal, clk, rst_n, 1'b1,
                       (n_reg != '0) && (n_ext <= MAX_EXT))
    `BRVW_ASSERT_NEXT(a_update_starts_divide, clk, rst_n, state_reg == ST_UPDATE,
                      (state_reg == ST_DIVIDE) && (div_cnt_reg == '0))

endmodule

`default_nettype wire

>>> test/brvw_window_checker.sv
// Checker that predicts and compares the range and volume means of every accepted bar.
module brvw_window_checker #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [brvw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [brvw_pkg::PDATA_W-1:0]  pwdata,
    input  wire logic                          run_done,
    brvw_bar_if                                bar,
    brvw_result_if                             result,
    output int                                 mismatches,
    output int                                 bars_taken,
    output int                                 results_taken
);
    import brvw_pkg::*;

    typedef struct packed {
        logic [MEAN_W-1:0] range_mean;
        logic [MEAN_W-1:0] volume_mean;
        logic              indicators_valid;
    } means_t;

    logic [WINDOW_W-1:0] window_len;
    logic [MINVOL_W-1:0] min_volume;
    logic [PRICE_W-1:0]  last_close;
    logic [PRICE_W-1:0]  range_hist [MAX_WINDOW];
    logic [VOLUME_W-1:0] volume_hist [MAX_WINDOW];
    logic [63:0]         range_total;
    logic [63:0]         volume_total;
    int unsigned         slot;
    int unsigned         bar_count;
    bit                  leftover_checked;
    means_t              means_expected [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    task automatic clear_history();
        last_close   = '0;
        range_total  = '0;
        volume_total = '0;
        slot         = 0;
        bar_count    = 0;
    endtask

    function automatic logic [63:0] price_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Applies one bar to the window and queues the means it must produce.
    task automatic predict_means(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                                 input logic [PRICE_W-1:0] cl, input logic [VOLUME_W-1:0] vol);
        logic [63:0] n;
        logic [63:0] tr;
        logic [63:0] d;
        logic [63:0] rm;
        logic [63:0] vm;
        int unsigned oldest;
        means_t      m;
        n  = 64'(window_len);
        tr = '0;
        rm = '0;
        vm = '0;
        if (bar_count > 0) begin
            tr = (hi >= lo) ? 64'(hi) - 64'(lo) : 64'd0;
            d  = price_gap(64'(hi), 64'(last_close));
            if (d > tr) tr = d;
            d  = price_gap(64'(lo), 64'(last_close));
            if (d > tr) tr = d;
        end
        // The entry leaving the window is read before its slot is reused.
        if (bar_count >= n) begin
            oldest       = (slot + MAX_WINDOW - int'(n)) % MAX_WINDOW;
            range_total  = range_total - 64'(range_hist[oldest]);
            volume_total = volume_total - 64'(volume_hist[oldest]);
        end
        range_hist[slot]  = tr[PRICE_W-1:0];
        volume_hist[slot] = vol;
        range_total       = range_total + tr;
        volume_total      = volume_total + 64'(vol);
        slot              = (slot + 1) % MAX_WINDOW;
        if (bar_count < MAX_WINDOW + 1) bar_count++;
        last_close = cl;
        if (bar_count >= n + 1) rm = (range_total << Q_SHIFT) / n;
        if (bar_count >= n) begin
            vm = (volume_total << Q_SHIFT) / n;
            if (vm == 0) vm = 64'(min_volume);
        end
        m.range_mean       = rm[MEAN_W-1:0];
        m.volume_mean      = vm[MEAN_W-1:0];
        m.indicators_valid = (rm != 0);
        means_expected.insert(means_expected.size(), m);
    endtask

    task automatic compare_means();
        means_t want;
        if (means_expected.size() == 0) begin
            report("result with no bar waiting", {result.range_mean_q8, 24'd0}, '0);
        end else begin
            want = means_expected.pop_front();
            if (result.range_mean_q8 !== want.range_mean)
                report("range_mean_q8", 64'(result.range_mean_q8), 64'(want.range_mean));
            if (result.volume_mean_q8 !== want.volume_mean)
                report("volume_mean_q8", 64'(result.volume_mean_q8), 64'(want.volume_mean));
            if (result.indicators_valid !== want.indicators_valid)
                report("indicators_valid", 64'(result.indicators_valid),
                       64'(want.indicators_valid));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_len       = WINDOW_RESET;
            min_volume       = MINVOL_RESET;
            leftover_checked = 1'b0;
            mismatches       = 0;
            clear_history();
            means_expected.delete();
            bars_taken    <= 0;
            results_taken <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[3] == REG_WINDOW) begin
                    window_len = pwdata[WINDOW_W-1:0];
                    if (window_len == 0) window_len = 1;
                    else if (window_len > MAX_WINDOW) window_len = WINDOW_W'(MAX_WINDOW);
                    clear_history();
                end else begin
                    min_volume = pwdata[MINVOL_W-1:0];
                end
            end
            if (result.valid && result.ready) begin
                compare_means();
                results_taken <= results_taken + 1;
            end
            if (bar.valid && bar.ready) begin
                predict_means(bar.bar_high, bar.bar_low, bar.bar_close, bar.bar_volume);
                bars_taken <= bars_taken + 1;
            end
            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (means_expected.size() != 0)
                    report("bars left without a result", '0, 64'(means_expected.size()));
            end
        end
    end

endmodule

>>> test/tb_bar_range_volume_window_top.sv
// Testbench top: drives bars and register writes into the window block and gives the verdict.
module tb_bar_range_volume_window_top;
    import brvw_pkg::*;

    localparam int MAX_WINDOW     = 64;
    // A correct run never goes this long without a request moving: the slowest
    // case is a sender gap, the divider latency and a receiver stall in a row.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 run_done;

    int                   mismatches;
    int                   bars_taken;
    int                   results_taken;
    int                   pending;
    int                   idle_cycles;
    int                   settings_count;
    bit                   idle_on;
    logic [PRICE_W-1:0]   price_base;

    brvw_bar_if    bar_ch ();
    brvw_result_if result_ch ();

    bar_range_volume_window_top #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bar     (bar_ch),
        .result  (result_ch)
    );

    brvw_window_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .run_done      (run_done),
        .bar           (bar_ch),
        .result        (result_ch),
        .mismatches    (mismatches),
        .bars_taken    (bars_taken),
        .results_taken (results_taken)
    );

    // Every accepted bar yields exactly one result, so the difference of the two
    // counts is the number of results still owed by the block.
    assign pending = bars_taken - results_taken;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The watchdog restarts whenever a request moves on either channel.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((bar_ch.valid && bar_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d cycles without a request", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result receiver: before each result it draws a random stall, or none while
    // idling is switched off. Ready is only lowered when a stall is actually taken,
    // so it never toggles twice in one time step.
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // One APB write: a setup phase, then an access phase that completes on pready.
    // An idle phase follows, so writes in a row never set psel twice in a step.
    task automatic write_reg(input logic reg_sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The window field is only seven bits wide; the upper data bits are filled
    // with noise that the block has to ignore. Any window write clears history.
    task automatic set_window(input int len);
        logic [PDATA_W-1:0] value;
        value = {$urandom, $urandom};
        value[WINDOW_W-1:0] = len[WINDOW_W-1:0];
        write_reg(REG_WINDOW, value);
        settings_count++;
    endtask

    task automatic set_min_volume(input logic [MINVOL_W-1:0] level);
        logic [PDATA_W-1:0] value;
        value = {$urandom, $urandom};
        value[MINVOL_W-1:0] = level;
        write_reg(REG_MIN_VOLUME, value);
    endtask

    // Presents one bar and returns at the edge where it was accepted. Valid is
    // only dropped when a gap is taken, so back-to-back bars keep it high.
    task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                            input logic [PRICE_W-1:0] cl, input logic [VOLUME_W-1:0] vol);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            bar_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bar_ch.valid      <= 1'b1;
        bar_ch.bar_high   <= hi;
        bar_ch.bar_low    <= lo;
        bar_ch.bar_close  <= cl;
        bar_ch.bar_volume <= vol;
        do @(posedge clk); while (!bar_ch.ready);
    endtask

    // Stops sending and waits until every owed result has come back. At least
    // one edge passes, so valid is never lowered and raised in the same step.
    task automatic drain();
        bar_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Most bars are well formed around a wandering price; the rest are raw
    // noise, rail values, or bars whose low lies above their high.
    task automatic send_random_bar();
        int                 kind;
        int                 vkind;
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] lo;
        logic [PRICE_W-1:0] cl;
        logic [VOLUME_W-1:0] vol;
        kind  = $urandom_range(0, 99);
        vkind = $urandom_range(0, 99);
        price_base = price_base + $urandom_range(0, 2000) - 1000;
        if (kind < 60) begin
            lo = price_base - $urandom_range(0, 500);
            hi = price_base + $urandom_range(0, 500);
            cl = lo + $urandom_range(0, 1000);
        end else if (kind < 75) begin
            hi = $urandom;
            lo = $urandom;
            cl = $urandom;
        end else if (kind < 85) begin
            hi = $urandom_range(0, 1) ? '1 : '0;
            lo = $urandom_range(0, 1) ? '1 : '0;
            cl = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            hi = price_base - $urandom_range(1, 400);
            lo = price_base + $urandom_range(1, 400);
            cl = price_base + $urandom_range(0, 800) - 400;
        end
        if (vkind < 30)      vol = '0;
        else if (vkind < 40) vol = '1;
        else if (vkind < 70) vol = $urandom_range(0, 1000);
        else                 vol = $urandom;
        send_bar(hi, lo, cl, vol);
    endtask

    initial begin
        int                  count;
        int                  win;
        logic [MINVOL_W-1:0] level;
        bit                  new_level;
        bit                  hold_mid;

        rst_n            = 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        run_done        <= 1'b0;
        bar_ch.valid      <= 1'b0;
        bar_ch.bar_high   <= '0;
        bar_ch.bar_low    <= '0;
        bar_ch.bar_close  <= '0;
        bar_ch.bar_volume <= '0;
        settings_count   = 1;
        idle_on          = 1'b1;
        price_base       = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A two-bar window makes the early, zero-volume and
        // zero-range cases show up within a handful of bars.
        set_window(2);
        set_min_volume('1);
        send_bar('1, '0, '1, '0);                  // first bar has no previous close
        send_bar('0, '1, '0, '0);                  // low above high, zero volume mean
        send_bar('1, '1, '1, '1);
        send_bar('0, '0, '0, '1);
        send_bar('1, '0, 32'h8000_0000, 32'h5555_5555);
        send_bar(32'h0000_1000, 32'h0000_2000, 32'h0000_1800, '0);
        send_bar(32'd100, 32'd90, 32'd95, '0);
        send_bar(32'd100, 32'd90, 32'd95, '0);
        send_bar(32'd50, 32'd50, 32'd50, 32'd7);
        send_bar(32'd50, 32'd50, 32'd50, '0);      // zero range; after the next bar the window holds no range at all
        send_bar(32'd50, 32'd50, 32'd50, '0);

        // A window of zero is taken as one; minimum volume of zero.
        drain();
        set_window(0);
        set_min_volume('0);
        send_bar(32'd5, 32'd3, 32'd4, '0);
        send_bar(32'd7, 32'd1, 32'd2, 32'd9);
        send_bar(32'd2, 32'd8, 32'd3, '0);
        send_bar('1, '1, '0, '0);

        // An oversized window is clamped to the full ring depth.
        drain();
        set_window(127);
        set_min_volume(40'd256);
        send_bar(32'd1000, 32'd900, 32'd950, 32'd10);
        send_bar(32'd1100, 32'd1000, 32'd1050, '0);
        send_bar(32'd900, 32'd800, 32'd850, 32'd20);

        // Random phases, each under its own register setting. One phase only
        // changes the minimum volume, so the history carries over into it.
        for (int p = 0; p < 8; p++) begin
            hold_mid  = 1'b0;
            new_level = 1'b1;
            level     = {8'($urandom_range(0, 255)), 32'($urandom)};
            case (p)
                0: begin win = $urandom_range(1, 3);  count = 50; end
                1: begin win = 64; level = 40'd256;    count = 90; end
                2: begin win = -1; level = '0;         count = 30; end
                3: begin win = 127;                    count = 80; end
                4: begin win = $urandom_range(1, 64); count = 50; new_level = 1'b0; end
                5: begin win = $urandom_range(2, 8); level = '1; count = 50; hold_mid = 1'b1; end
                6: begin win = 0;                      count = 30; end
                default: begin win = $urandom_range(1, 16); count = 40; end
            endcase
            drain();
            if (win >= 0) set_window(win);
            if (new_level) set_min_volume(level);
            for (int i = 0; i < count; i++) begin
                // Idling is switched on and off in stretches of 25 bars.
                if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
                // Once the sender holds off until the block has emptied.
                if (hold_mid && i == count / 2) drain();
                send_random_bar();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run covered %0d bars and %0d results under %0d window settings,",
                 bars_taken, results_taken, settings_count);
        $display("with zero and clamped windows, rail prices and inverted bars.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> bar_range_volume_window_top.f
+incdir+sv
sv/brvw_pkg.sv
sv/brvw_bar_if.sv
sv/brvw_result_if.sv
sv/brvw_ram.sv
sv/bar_range_volume_window_top.sv
test/brvw_window_checker.sv
test/tb_bar_range_volume_window_top.sv
